/* design/afc_pkg.sv */
`default_nettype none

package afc_pkg;

	// field widths
	localparam int COORD_WIDTH = 16;
	localparam int COEFF_WIDTH = 16;

	// configuration register layout
	localparam int NUM_COLS  = 4;
	localparam int NUM_AXES  = 3;
	localparam int NUM_LANES = 4;
	localparam int NUM_CORNERS = 8;
	localparam int LANE_WIDTH = 16;
	localparam int CFG_WIDTH  = LANE_WIDTH * NUM_LANES;
	localparam int CFG_IDX_WIDTH = 2;

	// column codes, also the configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] COL_X = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] COL_Y = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] COL_Z = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] COL_W = 2'd3;

	// lane holding the constant term
	localparam int LANE_ONE = 3;

	// arithmetic widths: three products plus one coefficient, then one more add
	localparam int PROD_WIDTH = COORD_WIDTH + COEFF_WIDTH;
	localparam int SUM_WIDTH  = PROD_WIDTH + 2;
	localparam int CMP_WIDTH  = SUM_WIDTH + 1;

	// Q3.12 one on the diagonal after reset
	localparam logic [COEFF_WIDTH-1:0] COEFF_ONE = COEFF_WIDTH'(4096);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;
	typedef logic signed [CMP_WIDTH-1:0]   cmp_t;
	typedef logic [CFG_WIDTH-1:0]          cfg_word_t;
	typedef logic [NUM_AXES-1:0]           axis_flags_t;

endpackage

`default_nettype wire

/* design/afc_mul.sv */
`default_nettype none

module afc_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               up_valid,
	output logic                    up_ready,
	input  wire afc_pkg::coord_t    lo [afc_pkg::NUM_AXES],
	input  wire afc_pkg::coord_t    hi [afc_pkg::NUM_AXES],
	input  wire afc_pkg::coeff_t    coeff [afc_pkg::NUM_COLS][afc_pkg::NUM_LANES],
	output logic                    dn_valid,
	input  wire logic               dn_ready,
	output afc_pkg::prod_t          prod_lo [afc_pkg::NUM_COLS][afc_pkg::NUM_AXES],
	output afc_pkg::prod_t          prod_hi [afc_pkg::NUM_COLS][afc_pkg::NUM_AXES]
);
	import afc_pkg::*;

	logic  valid_s1;
	prod_t prod_lo_s1 [NUM_COLS][NUM_AXES];
	prod_t prod_hi_s1 [NUM_COLS][NUM_AXES];

	// stage takes a new request when empty or when its content moves on
	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// one product per column, axis and box side
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					prod_lo_s1[c][a] <= prod_t'(lo[a]) * prod_t'(coeff[c][a]);
					prod_hi_s1[c][a] <= prod_t'(hi[a]) * prod_t'(coeff[c][a]);
				end
			end
		end
	end

	assign dn_valid = valid_s1;
	assign prod_lo = prod_lo_s1;
	assign prod_hi = prod_hi_s1;

endmodule

`default_nettype wire

/* design/afc_sum.sv */
`default_nettype none

module afc_sum (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               up_valid,
	output logic                    up_ready,
	input  wire afc_pkg::prod_t     prod_lo [afc_pkg::NUM_COLS][afc_pkg::NUM_AXES],
	input  wire afc_pkg::prod_t     prod_hi [afc_pkg::NUM_COLS][afc_pkg::NUM_AXES],
	input  wire afc_pkg::coeff_t    coeff [afc_pkg::NUM_COLS][afc_pkg::NUM_LANES],
	output logic                    dn_valid,
	input  wire logic               dn_ready,
	output afc_pkg::sum_t           clip [afc_pkg::NUM_COLS][afc_pkg::NUM_CORNERS]
);
	import afc_pkg::*;

	logic valid_s2;
	sum_t clip_s2 [NUM_COLS][NUM_CORNERS];

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	// corner bit k picks the max side of axis k
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				for (int n = 0; n < NUM_CORNERS; n++) begin
					clip_s2[c][n] <=
						sum_t'(n[0] ? prod_hi[c][0] : prod_lo[c][0]) +
						sum_t'(n[1] ? prod_hi[c][1] : prod_lo[c][1]) +
						sum_t'(n[2] ? prod_hi[c][2] : prod_lo[c][2]) +
						sum_t'(coeff[c][LANE_ONE]);
				end
			end
		end
	end

	assign dn_valid = valid_s2;
	assign clip = clip_s2;

endmodule

`default_nettype wire

/* design/afc_cmp.sv */
`default_nettype none

module afc_cmp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               up_valid,
	output logic                    up_ready,
	input  wire afc_pkg::sum_t      clip [afc_pkg::NUM_COLS][afc_pkg::NUM_CORNERS],
	output logic                    dn_valid,
	input  wire logic               dn_ready,
	output afc_pkg::axis_flags_t    above,
	output afc_pkg::axis_flags_t    below
);
	import afc_pkg::*;

	logic        valid_s3;
	axis_flags_t above_s3;
	axis_flags_t below_s3;
	axis_flags_t above_d;
	axis_flags_t below_d;

	assign up_ready = !valid_s3 || dn_ready;

	// c > -w as c + w > 0, c < w as w - c > 0, or-ed over the corners
	always_comb begin
		cmp_t plus;
		cmp_t minus;
		above_d = '0;
		below_d = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int n = 0; n < NUM_CORNERS; n++) begin
				plus  = cmp_t'(clip[COL_W][n]) + cmp_t'(clip[a][n]);
				minus = cmp_t'(clip[COL_W][n]) - cmp_t'(clip[a][n]);
				if (!plus[CMP_WIDTH-1] && (plus != '0)) begin
					above_d[a] = 1'b1;
				end
				if (!minus[CMP_WIDTH-1] && (minus != '0)) begin
					below_d[a] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			above_s3 <= above_d;
			below_s3 <= below_d;
		end
	end

	assign dn_valid = valid_s3;
	assign above = above_s3;
	assign below = below_s3;

endmodule

`default_nettype wire

/* design/aabb_frustum_cull.sv */
// channel   direction  handshake                 payload
// in        request    in_valid / in_stall       min_x min_y min_z max_x max_y max_z
// out       result     out_valid / out_stall     visible
// cfg       write      cfg_we                    cfg_index cfg_data
//
// one box per cycle sustained while out_stall is low; the result comes from the output register
// stages: corner products, corner clip sums, plane compares, output register
// each stage holds its own valid bit, so bubbles close up under a stalled output
// in_stall rises only when every stage is full and the output is stalled
// reset empties the pipeline and loads the identity clip matrix
`default_nettype none

module aabb_frustum_cull (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire afc_pkg::coord_t             min_x,
	input  wire afc_pkg::coord_t             min_y,
	input  wire afc_pkg::coord_t             min_z,
	input  wire afc_pkg::coord_t             max_x,
	input  wire afc_pkg::coord_t             max_y,
	input  wire afc_pkg::coord_t             max_z,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             visible,
	input  wire logic                        cfg_we,
	input  wire logic [afc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  wire logic [afc_pkg::CFG_WIDTH-1:0]     cfg_data
);
	import afc_pkg::*;

	cfg_word_t   cfg_q [NUM_COLS];
	coeff_t      coeff [NUM_COLS][NUM_LANES];
	coord_t      lo [NUM_AXES];
	coord_t      hi [NUM_AXES];
	logic        mul_ready;
	logic        mul_valid;
	logic        sum_ready;
	logic        sum_valid;
	logic        cmp_ready;
	logic        cmp_valid;
	logic        out_ready;
	prod_t       prod_lo [NUM_COLS][NUM_AXES];
	prod_t       prod_hi [NUM_COLS][NUM_AXES];
	sum_t        clip [NUM_COLS][NUM_CORNERS];
	axis_flags_t above;
	axis_flags_t below;
	logic        out_valid_q;
	logic        visible_q;

	// clip matrix columns, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				cfg_q[c] <= cfg_word_t'(COEFF_ONE) << (LANE_WIDTH * c);
			end
		end else if (cfg_we) begin
			case (cfg_index)
				COL_X:   cfg_q[COL_X] <= cfg_data;
				COL_Y:   cfg_q[COL_Y] <= cfg_data;
				COL_Z:   cfg_q[COL_Z] <= cfg_data;
				COL_W:   cfg_q[COL_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	// low bits of each lane as a signed coefficient
	always_comb begin
		for (int c = 0; c < NUM_COLS; c++) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				coeff[c][l] = coeff_t'(cfg_q[c][LANE_WIDTH*l +: COEFF_WIDTH]);
			end
		end
	end

	assign lo[0] = min_x;
	assign lo[1] = min_y;
	assign lo[2] = min_z;
	assign hi[0] = max_x;
	assign hi[1] = max_y;
	assign hi[2] = max_z;

	afc_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (mul_ready),
		.lo       (lo),
		.hi       (hi),
		.coeff    (coeff),
		.dn_valid (mul_valid),
		.dn_ready (sum_ready),
		.prod_lo  (prod_lo),
		.prod_hi  (prod_hi)
	);

	assign in_stall = !mul_ready;

	afc_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mul_valid),
		.up_ready (sum_ready),
		.prod_lo  (prod_lo),
		.prod_hi  (prod_hi),
		.coeff    (coeff),
		.dn_valid (sum_valid),
		.dn_ready (cmp_ready),
		.clip     (clip)
	);

	afc_cmp u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sum_valid),
		.up_ready (cmp_ready),
		.clip     (clip),
		.dn_valid (cmp_valid),
		.dn_ready (out_ready),
		.above    (above),
		.below    (below)
	);

	// output register: all three axes must keep a corner on each side
	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= cmp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && cmp_valid) begin
			visible_q <= (&above) && (&below);
		end
	end

	assign out_valid = out_valid_q;
	assign visible = visible_q;

	// back-pressure reaches the input only with every stage occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (mul_valid && sum_valid && cmp_valid && out_valid_q && out_stall))
		else $error("input stalled with a free pipeline stage");

	// an accepted request lands in the first stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> mul_valid)
		else $error("accepted request lost at the first stage");

	// a held compare stage keeps its flags
	a_cmp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_valid && !out_ready) |=> (cmp_valid && $stable(above) && $stable(below)))
		else $error("compare stage changed while held");

endmodule

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import afc_pkg::*;

	// cycles allowed after the last result so the pipeline is surely empty
	localparam int SETTLE_CYCLES   = 8;
	localparam int RANDOM_PHASES   = 7;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int EXTREME_ITEMS   = 30;
	localparam int IDENTITY_ITEMS  = 100;

	typedef struct {
		coord_t lo[NUM_AXES];
		coord_t hi[NUM_AXES];
	} box_t;

	// identity matrix column: one Q3.12 unit in lane i
	function automatic cfg_word_t unit_lane(int i);
		return cfg_word_t'(COEFF_ONE) << (LANE_WIDTH * i);
	endfunction

	// visibility predictor and queue of expected flags
	class cull_scoreboard;
		cfg_word_t column[NUM_COLS];
		bit        visible_q[$];
		int        errors;

		function new();
			for (int i = 0; i < NUM_COLS; i++)
				column[i] = unit_lane(i);
			errors = 0;
		endfunction

		function void set_column(logic [CFG_IDX_WIDTH-1:0] idx, cfg_word_t data);
			column[idx] = data;
		endfunction

		// (x, y, z, 1) dotted with one column, exact, in Q.12 units
		function longint lane_dot(cfg_word_t col, longint pt[NUM_AXES]);
			longint acc;
			acc = longint'(coeff_t'(col[LANE_WIDTH*LANE_ONE +: COEFF_WIDTH]));
			for (int i = 0; i < NUM_AXES; i++)
				acc += pt[i] * longint'(coeff_t'(col[LANE_WIDTH*i +: COEFF_WIDTH]));
			return acc;
		endfunction

		function bit predict_visible(box_t b);
			longint pt[NUM_AXES];
			longint clip_w;
			longint clip_c;
			bit     above[NUM_AXES];
			bit     below[NUM_AXES];
			bit     vis;
			for (int k = 0; k < NUM_AXES; k++) begin
				above[k] = 1'b0;
				below[k] = 1'b0;
			end
			// walk all eight corners, each axis picks min or max by a corner bit
			for (int c = 0; c < NUM_CORNERS; c++) begin
				for (int k = 0; k < NUM_AXES; k++)
					pt[k] = c[k] ? longint'(b.hi[k]) : longint'(b.lo[k]);
				clip_w = lane_dot(column[COL_W], pt);
				for (int k = 0; k < NUM_AXES; k++) begin
					clip_c = lane_dot(column[k], pt);
					if (clip_c > -clip_w) above[k] = 1'b1;
					if (clip_c < clip_w)  below[k] = 1'b1;
				end
			end
			vis = 1'b1;
			for (int k = 0; k < NUM_AXES; k++)
				if (!above[k] || !below[k]) vis = 1'b0;
			return vis;
		endfunction

		function void note_request(box_t b);
			visible_q.push_back(predict_visible(b));
		endfunction

		function void check_visible(logic got);
			bit want;
			if (visible_q.size() == 0) begin
				$error("visible: result with no request pending, got %0b", got);
				errors++;
				return;
			end
			want = visible_q.pop_front();
			if (got !== want) begin
				$error("visible mismatch: expected %0b, got %0b", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return visible_q.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	coord_t                   min_x, min_y, min_z;
	coord_t                   max_x, max_y, max_z;
	logic                     out_valid;
	logic                     out_stall;
	logic                     visible;
	logic                     cfg_we;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	cfg_word_t                cfg_data;

	cull_scoreboard sb = new();
	int             burst_left = 0;

	aabb_frustum_cull u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.min_x     (min_x),
		.min_y     (min_y),
		.min_z     (min_z),
		.max_x     (max_x),
		.max_y     (max_y),
		.max_z     (max_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.visible   (visible),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	// output stall pattern, switching between randomly chosen modes
	initial begin
		int mode;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 80)) begin
				@(negedge clk);
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 99) < 30);
					2: out_stall = ($urandom_range(0, 99) < 75);
					default: out_stall = ~out_stall;
				endcase
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_visible(visible);
	end

	function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
		box_t b;
		b.lo[0] = coord_t'(lx);
		b.lo[1] = coord_t'(ly);
		b.lo[2] = coord_t'(lz);
		b.hi[0] = coord_t'(hx);
		b.hi[1] = coord_t'(hy);
		b.hi[2] = coord_t'(hz);
		return b;
	endfunction

	function automatic coord_t rand_coord(int span);
		return coord_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic logic [LANE_WIDTH-1:0] rand_lane(int lo_v, int hi_v);
		return LANE_WIDTH'(int'($urandom_range(0, hi_v - lo_v)) + lo_v);
	endfunction

	// mostly ordered boxes of mixed size, some raw noise and point boxes
	function automatic box_t rand_box();
		box_t   b;
		int     kind;
		int     span;
		coord_t a, c;
		kind = $urandom_range(0, 9);
		span = (kind % 3 == 0) ? 16 : (kind % 3 == 1) ? 512 : 8192;
		for (int k = 0; k < NUM_AXES; k++) begin
			if (kind <= 1) begin
				b.lo[k] = coord_t'($urandom);
				b.hi[k] = coord_t'($urandom);
			end else if (kind <= 8) begin
				a = (kind >= 7) ? coord_t'($urandom) : rand_coord(span);
				c = (kind >= 7) ? coord_t'($urandom) : rand_coord(span);
				b.lo[k] = (a < c) ? a : c;
				b.hi[k] = (a < c) ? c : a;
			end else begin
				a = rand_coord(span);
				b.lo[k] = a;
				b.hi[k] = a;
			end
		end
		return b;
	endfunction

	// one request, with a random gap whenever a burst runs out
	task automatic send_box(input box_t b);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		min_x = b.lo[0];
		min_y = b.lo[1];
		min_z = b.lo[2];
		max_x = b.hi[0];
		max_y = b.hi[1];
		max_z = b.hi[2];
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_request(b);
		burst_left--;
		@(negedge clk);
	endtask

	// stop sending and wait for every pending result
	task automatic drain_results();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_column(input logic [CFG_IDX_WIDTH-1:0] idx, input cfg_word_t data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_column(idx, data);
	endtask

	task automatic set_matrix(input cfg_word_t cx, input cfg_word_t cy,
			input cfg_word_t cz, input cfg_word_t cw);
		drain_results();
		write_column(COL_X, cx);
		write_column(COL_Y, cy);
		write_column(COL_Z, cz);
		write_column(COL_W, cw);
	endtask

	// fully random matrix, or a perspective-like one with w driven by z
	task automatic random_matrix();
		cfg_word_t col[NUM_COLS];
		if ($urandom_range(0, 2) == 0) begin
			for (int i = 0; i < NUM_COLS; i++)
				col[i] = {$urandom, $urandom};
		end else begin
			for (int i = 0; i < NUM_AXES; i++) begin
				col[i] = {rand_lane(-32768, 32767), rand_lane(-512, 512),
					rand_lane(-512, 512), rand_lane(-512, 512)};
				col[i][LANE_WIDTH*i +: LANE_WIDTH] = rand_lane(-8192, 8192);
			end
			col[COL_W] = {rand_lane(-32768, 32767), rand_lane(1024, 8192),
				rand_lane(-256, 256), rand_lane(-256, 256)};
		end
		set_matrix(col[COL_X], col[COL_Y], col[COL_Z], col[COL_W]);
	endtask

	task automatic run_random(input int count, input bit pause_midway);
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				drain_results();
			send_box(rand_box());
		end
	endtask

	// main sequence
	initial begin
		in_valid  = 1'b0;
		min_x     = '0;
		min_y     = '0;
		min_z     = '0;
		max_x     = '0;
		max_y     = '0;
		max_z     = '0;
		cfg_we    = 1'b0;
		cfg_index = COL_X;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// identity matrix from reset: strict edges, extremes, inverted boxes
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
		send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
		send_box(mk_box(-1, -1, -1, -1, -1, -1));
		send_box(mk_box(1, 1, 1, 1, 1, 1));
		send_box(mk_box(-1, 0, 0, 1, 0, 0));
		send_box(mk_box(0, -5, 0, 0, -1, 0));
		send_box(mk_box(0, 0, 1, 0, 0, 3));
		send_box(mk_box(3, 0, 0, -3, 0, 0));
		send_box(mk_box(-21846, 21845, -21846, 21845, -21846, 21845));
		run_random(IDENTITY_ITEMS, 1'b1);

		// w zero everywhere: never visible
		set_matrix('0, '0, '0, '0);
		send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
		run_random(EXTREME_ITEMS, 1'b0);

		// w negative at every corner
		set_matrix(unit_lane(COL_X), unit_lane(COL_Y), unit_lane(COL_Z),
			cfg_word_t'(16'h8000) << (LANE_WIDTH * LANE_ONE));
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		run_random(EXTREME_ITEMS, 1'b0);

		// coefficient extremes in every lane
		set_matrix('1, '1, '1, '1);
		send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
		run_random(EXTREME_ITEMS, 1'b0);
		set_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
		send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
		run_random(EXTREME_ITEMS, 1'b0);
		set_matrix({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
		send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
		run_random(EXTREME_ITEMS, 1'b0);

		// random matrices
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_matrix();
			run_random(ITEMS_PER_PHASE, p == 0);
		end

		drain_results();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
